// ===== sv/sdd_pkg.sv =====
// Shared types, constants and register codes for the sensor disconnect detector.
package sdd_pkg;

  // Field widths
  localparam int CH_W       = 2;
  localparam int ADC_W      = 24;
  localparam int CODE_SHIFT = 4;
  localparam int CODE_W     = ADC_W - CODE_SHIFT;
  localparam int THR_W      = 20;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 4;

  // Threshold registers exist for every channel slot the channel field can name
  localparam int NUM_THR = 1 << CH_W;

  // Defaults for the top-level parameters
  localparam int NUM_CHANNELS_DEF   = 4;
  localparam int DEBOUNCE_LIMIT_DEF = 5;

  // Debounce counter saturates here
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Threshold reset values
  localparam logic [THR_W-1:0] HI_THR_RST = {THR_W{1'b1}};
  localparam logic [THR_W-1:0] LO_THR_RST = '0;

  // Register map: high thresholds first, then low thresholds
  localparam logic [CFG_IDX_W-1:0] CFG_HI_THR_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LO_THR_BASE = CFG_IDX_W'(NUM_THR);
  localparam logic [CFG_IDX_W-1:0] CFG_END         = CFG_IDX_W'(2 * NUM_THR);

  // Per-channel link state, encoded as reported on the result channel
  typedef enum logic [1:0] {
    LINK_CONNECTED    = 2'd0,
    LINK_MAYBE_DISC   = 2'd1,
    LINK_DISCONNECTED = 2'd2,
    LINK_MAYBE_CONN   = 2'd3
  } link_state_t;

  // One entry of the per-channel state memory
  typedef struct packed {
    link_state_t        state;
    logic [CNT_W-1:0]   count;
    logic [THR_W-1:0]   hi_lat;
    logic [THR_W-1:0]   lo_lat;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    state:  LINK_CONNECTED,
    count:  '0,
    hi_lat: '0,
    lo_lat: '0
  };

  // Operands for one channel update
  typedef struct packed {
    entry_t             cur;
    logic [CODE_W-1:0]  code;
    logic [THR_W-1:0]   hi_thr;
    logic [THR_W-1:0]   lo_thr;
  } upd_req_t;

endpackage

// ===== sv/sdd_in_if.sv =====
// Sample channel: channel number and raw ADC sample with valid/ready.
interface sdd_in_if;
  logic                          valid;
  logic                          ready;
  logic [sdd_pkg::CH_W-1:0]      channel;
  logic [sdd_pkg::ADC_W-1:0]     adc_raw;

  modport source (output valid, output channel, output adc_raw, input ready);
  modport sink   (input valid, input channel, input adc_raw, output ready);
endinterface

// ===== sv/sdd_out_if.sv =====
// Status channel: channel number, fault flag and link state with valid/ready.
interface sdd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdd_pkg::CH_W-1:0]      out_channel;
  logic                          fault;
  logic [1:0]                    link_state;

  modport source (output valid, output out_channel, output fault, output link_state,
                  input ready);
  modport sink   (input valid, input out_channel, input fault, input link_state,
                  output ready);
endinterface

// ===== sv/sdd_cfg_if.sv =====
// Register write channel: index and data with valid/ready.
interface sdd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sdd_pkg::CFG_IDX_W-1:0]     index;
  logic [sdd_pkg::THR_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sdd_link_fsm.sv =====
// Next-entry logic for one channel: hysteresis compare and debounce count.
module sdd_link_fsm #(
  parameter int DEBOUNCE_LIMIT = sdd_pkg::DEBOUNCE_LIMIT_DEF
) (
  input  sdd_pkg::upd_req_t  req,
  output sdd_pkg::entry_t    nxt
);

  localparam logic [sdd_pkg::CNT_W-1:0] LIMIT = sdd_pkg::CNT_W'(DEBOUNCE_LIMIT);

  logic [sdd_pkg::CNT_W-1:0] cnt_inc;
  logic                      cnt_done;

  // Saturating count step
  assign cnt_inc  = (req.cur.count == sdd_pkg::CNT_MAX) ? req.cur.count
                                                        : req.cur.count + 1'b1;
  assign cnt_done = (cnt_inc > LIMIT);

  // Advance the channel's link state; the override compare has the last word
  always_comb begin
    nxt = req.cur;
    case (req.cur.state)
      sdd_pkg::LINK_CONNECTED: begin
        nxt.hi_lat = req.hi_thr;
        if (req.code > req.hi_thr) begin
          nxt.count = '0;
          nxt.state = sdd_pkg::LINK_MAYBE_DISC;
        end
      end
      sdd_pkg::LINK_MAYBE_DISC: begin
        nxt.count = cnt_inc;
        if (cnt_done) nxt.state = sdd_pkg::LINK_DISCONNECTED;
        if (req.code < req.cur.hi_lat) nxt.state = sdd_pkg::LINK_CONNECTED;
      end
      sdd_pkg::LINK_DISCONNECTED: begin
        nxt.lo_lat = req.lo_thr;
        if (req.code < req.lo_thr) begin
          nxt.count = '0;
          nxt.state = sdd_pkg::LINK_MAYBE_CONN;
        end
      end
      sdd_pkg::LINK_MAYBE_CONN: begin
        nxt.count = cnt_inc;
        if (cnt_done) nxt.state = sdd_pkg::LINK_CONNECTED;
        if (req.code > req.cur.lo_lat) nxt.state = sdd_pkg::LINK_DISCONNECTED;
      end
      default: begin
        nxt = req.cur;
      end
    endcase
  end

endmodule

// ===== sv/sensor_disconnect_detector_top.sv =====
// Top level of the sensor disconnect detector: state memory, pipeline and registers.
//
//  Channel   Dir  Handshake      Payload
//  in_if     in   valid/ready    channel[1:0], adc_raw[23:0]
//  out_if    out  valid/ready    out_channel[1:0], fault, link_state[1:0]
//  cfg_if    in   valid/ready    index[3:0], data[19:0] (ready always high)
//
// One sample per cycle sustained while the output is accepted; after its transfer a
// result passes the memory read register, then the update into the output register.
// Per-channel state sits in a one-read one-write memory; the entry written last is
// forwarded to the next read. A held output register stalls the update stage, which
// then stalls the input. Reset clears valid bits, pipeline and thresholds.
module sensor_disconnect_detector_top #(
  parameter int NUM_CHANNELS   = sdd_pkg::NUM_CHANNELS_DEF,
  parameter int DEBOUNCE_LIMIT = sdd_pkg::DEBOUNCE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  sdd_in_if.sink            in_if,
  sdd_out_if.source         out_if,
  sdd_cfg_if.sink           cfg_if
);

  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [sdd_pkg::CH_W:0] NUM_CH_V = (sdd_pkg::CH_W + 1)'(NUM_CHANNELS);

  // Threshold registers
  logic [sdd_pkg::THR_W-1:0] hi_thr_r [sdd_pkg::NUM_THR];
  logic [sdd_pkg::THR_W-1:0] lo_thr_r [sdd_pkg::NUM_THR];

  // State memory, valid bits and forwarding register
  sdd_pkg::entry_t           mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]   ent_vld_r;
  sdd_pkg::entry_t           rd_data_r;
  logic                      fwd_valid_r;
  logic [ADDR_W-1:0]         fwd_addr_r;
  sdd_pkg::entry_t           fwd_entry_r;

  // Update stage
  logic                          s1_valid_r, s1_valid_nxt;
  logic [sdd_pkg::CH_W-1:0]      s1_ch_r;
  logic [sdd_pkg::CODE_W-1:0]    s1_code_r;
  logic                          s1_in_range_r;
  logic                          s1_ent_vld_r;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [sdd_pkg::CH_W-1:0]      out_ch_r;
  logic                          out_fault_r;
  sdd_pkg::link_state_t          out_state_r;

  logic                          in_fire;
  logic                          in_range;
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             s1_addr;
  logic                          s1_adv;
  logic                          mem_we;
  sdd_pkg::upd_req_t             upd_req;
  sdd_pkg::entry_t               wr_entry;
  sdd_pkg::link_state_t          res_state;

  // Configuration writes; out-of-map indexes are dropped
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sdd_pkg::NUM_THR; i++) begin
        hi_thr_r[i] <= sdd_pkg::HI_THR_RST;
        lo_thr_r[i] <= sdd_pkg::LO_THR_RST;
      end
    end else if (cfg_if.valid) begin
      if (cfg_if.index < sdd_pkg::CFG_LO_THR_BASE) begin
        hi_thr_r[cfg_if.index[sdd_pkg::CH_W-1:0]] <= cfg_if.data;
      end else if (cfg_if.index < sdd_pkg::CFG_END) begin
        lo_thr_r[cfg_if.index[sdd_pkg::CH_W-1:0]] <= cfg_if.data;
      end
    end
  end

  // Handshake and stage control
  assign in_fire      = in_if.valid && in_if.ready;
  assign in_range     = ({1'b0, in_if.channel} < NUM_CH_V);
  assign rd_addr      = in_range ? in_if.channel[ADDR_W-1:0] : '0;
  assign s1_addr      = s1_ch_r[ADDR_W-1:0];
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign mem_we       = s1_adv && s1_in_range_r;
  assign in_if.ready  = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)     s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_adv)             out_valid_nxt = 1'b1;
    else if (out_if.ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Memory: registered read on transfer, write back on update
  always_ff @(posedge clk) begin
    if (mem_we) mem[s1_addr] <= wr_entry;
    if (in_fire) rd_data_r <= mem[rd_addr];
  end

  // Valid bits and the last written entry for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else if (mem_we) begin
      ent_vld_r[s1_addr] <= 1'b1;
      fwd_valid_r        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_addr_r  <= s1_addr;
      fwd_entry_r <= wr_entry;
    end
  end

  // Capture the sample into the update stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r       <= in_if.channel;
      s1_code_r     <= in_if.adc_raw[sdd_pkg::ADC_W-1:sdd_pkg::CODE_SHIFT];
      s1_in_range_r <= in_range;
      s1_ent_vld_r  <= ent_vld_r[rd_addr];
    end
  end

  // Select the current entry: forwarded, stored, or reset value
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr)) upd_req.cur = fwd_entry_r;
    else if (s1_ent_vld_r)                      upd_req.cur = rd_data_r;
    else                                        upd_req.cur = sdd_pkg::ENTRY_RST;
    upd_req.code   = s1_code_r;
    upd_req.hi_thr = hi_thr_r[s1_ch_r];
    upd_req.lo_thr = lo_thr_r[s1_ch_r];
  end

  sdd_link_fsm #(
    .DEBOUNCE_LIMIT (DEBOUNCE_LIMIT)
  ) u_link_fsm (
    .req (upd_req),
    .nxt (wr_entry)
  );

  // Load the result; absent channels report connected without fault
  assign res_state = s1_in_range_r ? wr_entry.state : sdd_pkg::LINK_CONNECTED;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch_r    <= s1_ch_r;
      out_state_r <= res_state;
      out_fault_r <= res_state inside {sdd_pkg::LINK_DISCONNECTED, sdd_pkg::LINK_MAYBE_CONN};
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_channel = out_ch_r;
  assign out_if.fault       = out_fault_r;
  assign out_if.link_state  = out_state_r;

  // Checks
  a_no_write_absent: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, s1_ch_r} < NUM_CH_V))
    else $error("state memory written for an absent channel");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a stage was free");

  a_no_skip_debounce: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (upd_req.cur.state == sdd_pkg::LINK_CONNECTED)) |->
      (wr_entry.state != sdd_pkg::LINK_DISCONNECTED))
    else $error("link went from connected to disconnected without debounce");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (fwd_valid_r && (fwd_addr_r == $past(s1_addr))))
    else $error("forwarding register missed a write-back");

endmodule
